FILE: hdl/srdim_pkg.sv
// shared types, constants and arithmetic helpers for the soft-ramp dimmer
// no dependencies; imported by the dimmer top level and its port checker
package srdim_pkg;

  localparam int MODE_W    = 2;
  localparam int PCT_W     = 16;
  localparam int LEVEL_W   = 8;
  localparam int TIMING_W  = 16;
  localparam int COUNT_W   = 2 * TIMING_W;
  localparam int CFG_IDX_W = 2;

  // input beat: mode, level_percent, zero pad to whole bytes
  localparam int IN_BITS   = MODE_W + PCT_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // output beat: pwm_duty, duty_changed, current_level, target_level
  localparam int OUT_BITS   = 3 * LEVEL_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int OUT_DUTY_LSB    = 0;
  localparam int OUT_CHANGED_BIT = LEVEL_W;
  localparam int OUT_CUR_LSB     = LEVEL_W + 1;
  localparam int OUT_TGT_LSB     = 2 * LEVEL_W + 1;

  // percent to level: p*255/100 == (p * 1336965) >> 19 for p in 0..100
  localparam int PCT_MAX       = 100;
  localparam int PCT_SCALE     = 1336965;
  localparam int PCT_SCALE_W   = 21;
  localparam int PCT_SHIFT     = 19;
  localparam int PCT_IDX_W     = 7;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET  = 2'd0,
    MODE_RAMP = 2'd1,
    MODE_TICK = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT_SECONDS   = 2'd0,
    REG_CYCLES_PER_SECOND = 2'd1,
    REG_SPARE_2           = 2'd2,
    REG_SPARE_3           = 2'd3
  } cfg_reg_t;

  // clamped percent to 0..255 target level
  function automatic logic [LEVEL_W-1:0] level_map(input logic signed [PCT_W-1:0] pct);
    logic [PCT_IDX_W+PCT_SCALE_W-1:0] prod;
    // unsigned operands: 0..100 needs all 7 bits as magnitude
    prod = pct[PCT_IDX_W-1:0] * PCT_SCALE_W'(unsigned'(PCT_SCALE));
    if (pct < 0) begin
      level_map = '0;
    end else if (pct > PCT_MAX) begin
      level_map = LEVEL_FULL;
    end else begin
      level_map = prod[PCT_SHIFT +: LEVEL_W];
    end
  endfunction

  // c*c/255 truncated, divide done as (x + (x >> 8) + 1) >> 8, exact for x < 65535
  function automatic logic [LEVEL_W-1:0] duty_of(input logic [LEVEL_W-1:0] lvl);
    logic [2*LEVEL_W-1:0] sq;
    logic [2*LEVEL_W:0]   acc;
    sq  = lvl * lvl;
    acc = {1'b0, sq} + {{(LEVEL_W+1){1'b0}}, sq[2*LEVEL_W-1:LEVEL_W]} + 1'b1;
    duty_of = acc[LEVEL_W +: LEVEL_W];
  endfunction

endpackage

FILE: hdl/soft_ramp_dimmer_with_timeout_top.sv
// soft-ramp led dimmer with inactivity timeout, single-pass update per beat
// depends on srdim_pkg
//
// usage
//   in_*  : command beats. tdata = {pad, level_percent[15:0], mode[1:0]}
//           mode 0 sets the target from a percent level and reloads the
//           countdown, mode 1 moves the current level one count toward the
//           target, mode 2 is a timer tick, mode 3 only reports state
//   out_* : one result beat per command beat, in order
//   cfg_* : write-only register port, index 0 timeout_seconds,
//           index 1 cycles_per_second; either write reloads the countdown
//           with timeout_seconds * cycles_per_second. only write while idle
// timing
//   each command updates the level and countdown registers at the edge it
//   is accepted and its result sits in the output register one cycle later.
//   one beat per cycle sustained; the loop is the level/countdown register
//   update, which is one compare, one 8x8 square and one 16x16 reload product
// reset
//   synchronous, active low: levels, countdown and timing registers clear,
//   output register empties
// back-pressure
//   in_tready drops only while a result is held and out_tready is low; the
//   held result stays stable until it is taken
module soft_ramp_dimmer_with_timeout_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // command beat: [1:0] mode, [17:2] level_percent, upper bits zero
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [srdim_pkg::IN_DATA_W-1:0]  in_tdata,
  // result beat: [7:0] pwm_duty, [8] duty_changed, [16:9] current_level,
  // [24:17] target_level, upper bits zero
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [srdim_pkg::OUT_DATA_W-1:0] out_tdata,
  // register writes
  input  logic                             cfg_we,
  input  logic [srdim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srdim_pkg::TIMING_W-1:0]   cfg_wdata
);
  import srdim_pkg::*;

  // timing registers
  logic [TIMING_W-1:0] timeout_s_r, timeout_s_nxt;
  logic [TIMING_W-1:0] cps_r, cps_nxt;

  // dimmer state
  logic [LEVEL_W-1:0]  target_r, target_nxt;
  logic [LEVEL_W-1:0]  current_r, current_nxt;
  logic [COUNT_W-1:0]  countdown_r, countdown_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // decoded command
  mode_t                   mode;
  logic signed [PCT_W-1:0] pct;
  logic                    in_beat;
  logic                    changed;
  logic                    apply;

  // shared reload multiplier, operands steered by a register write
  logic [TIMING_W-1:0] mul_a, mul_b;
  logic [COUNT_W-1:0]  reload;
  logic                cfg_hit;

  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;
  assign mode      = mode_t'(in_tdata[MODE_W-1:0]);
  assign pct       = signed'(in_tdata[MODE_W +: PCT_W]);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // config write path
  always_comb begin
    timeout_s_nxt = timeout_s_r;
    cps_nxt       = cps_r;
    cfg_hit       = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIMEOUT_SECONDS: begin
          timeout_s_nxt = cfg_wdata;
          cfg_hit       = 1'b1;
        end
        REG_CYCLES_PER_SECOND: begin
          cps_nxt = cfg_wdata;
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // reload uses the value being written, if any
  assign mul_a  = timeout_s_nxt;
  assign mul_b  = cps_nxt;
  assign reload = mul_a * mul_b;

  // per-beat state update
  always_comb begin
    target_nxt    = target_r;
    current_nxt   = current_r;
    countdown_nxt = countdown_r;
    changed       = 1'b0;
    apply         = 1'b0;

    if (in_beat) begin
      unique case (mode)
        MODE_SET: begin
          apply = 1'b1;
        end
        MODE_RAMP: begin
          if (current_r < target_r) begin
            current_nxt = current_r + 1'b1;
            changed     = 1'b1;
          end else if (current_r > target_r) begin
            current_nxt = current_r - 1'b1;
            changed     = 1'b1;
          end
        end
        MODE_TICK: begin
          // timeout disabled when timeout_seconds is zero
          if (timeout_s_r != '0) begin
            if (countdown_r != '0) begin
              countdown_nxt = countdown_r - 1'b1;
            end else begin
              apply = 1'b1;
            end
          end
        end
        default: begin
          changed = 1'b0;
        end
      endcase
    end

    if (apply) begin
      target_nxt    = level_map(pct);
      countdown_nxt = reload;
    end

    // a write to timeout_seconds or cycles_per_second also reloads the countdown
    if (cfg_hit) begin
      countdown_nxt = reload;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_beat) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[OUT_DUTY_LSB +: LEVEL_W] = duty_of(current_nxt);
      out_data_nxt[OUT_CHANGED_BIT]         = changed;
      out_data_nxt[OUT_CUR_LSB +: LEVEL_W]  = current_nxt;
      out_data_nxt[OUT_TGT_LSB +: LEVEL_W]  = target_nxt;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_s_r <= '0;
      cps_r       <= '0;
      target_r    <= '0;
      current_r   <= '0;
      countdown_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      timeout_s_r <= timeout_s_nxt;
      cps_r       <= cps_nxt;
      target_r    <= target_nxt;
      current_r   <= current_nxt;
      countdown_r <= countdown_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: hdl/srdim_port_checker.sv
// port-level checks for the soft-ramp dimmer, bound to its top level
// depends on srdim_pkg and soft_ramp_dimmer_with_timeout_top
module srdim_port_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [srdim_pkg::OUT_DATA_W-1:0] out_tdata
);
  import srdim_pkg::*;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid right after reset");

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // with nothing held the block takes a command
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result register");

  // squared duty never exceeds the level it comes from
  a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DUTY_LSB +: LEVEL_W] <= out_tdata[OUT_CUR_LSB +: LEVEL_W])
    else $error("duty above current level");

endmodule

bind soft_ramp_dimmer_with_timeout_top srdim_port_checker u_srdim_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: sim/tb_soft_ramp_dimmer_with_timeout_top.sv
// self-checking bench for the soft-ramp dimmer: directed corners, back-pressure and random beats
// expected beats come from a cycle-free predictor of levels and countdown
// depends on srdim_pkg and soft_ramp_dimmer_with_timeout_top
`timescale 1ns / 100ps

module tb_soft_ramp_dimmer_with_timeout_top;
  import srdim_pkg::*;

  // one result beat split into its fields
  typedef struct packed {
    logic [LEVEL_W-1:0] duty;
    logic               changed;
    logic [LEVEL_W-1:0] cur;
    logic [LEVEL_W-1:0] tgt;
  } dim_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [TIMING_W-1:0]   cfg_wdata;

  soft_ramp_dimmer_with_timeout_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // predictor state, mirrors the block's registers
  logic [TIMING_W-1:0] timeout_s;
  logic [TIMING_W-1:0] ticks_per_s;
  logic [LEVEL_W-1:0]  tgt_lvl;
  logic [LEVEL_W-1:0]  cur_lvl;
  logic [COUNT_W-1:0]  countdown_q;

  // results still owed by the block, oldest first
  dim_result_t pending[$];

  int n_errors;
  int n_results;
  int n_moves;
  int n_expiries;
  int n_reg_writes;

  // idle odds in percent for each side, set per phase
  int src_idle_pct;
  int sink_idle_pct;

  // receiver hold-off request: the test flips stall_tog, the ready process counts
  logic stall_tog;
  int   stall_len;

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous ceiling on the whole run
  initial begin
    #5_000_000;
    $display("tb_soft_ramp_dimmer_with_timeout_top: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // clamp percent and scale to 0..255, truncating
  function automatic logic [LEVEL_W-1:0] pct_to_level(input logic signed [PCT_W-1:0] pct);
    int p;
    p = pct;
    if (p < 0) return '0;
    if (p > 100) return 8'd255;
    return LEVEL_W'((p * 255) / 100);
  endfunction

  // target from percent and a fresh countdown, as a set command does
  function automatic void take_level(input logic signed [PCT_W-1:0] pct);
    tgt_lvl     = pct_to_level(pct);
    countdown_q = COUNT_W'(timeout_s) * COUNT_W'(ticks_per_s);
  endfunction

  function automatic void write_timing(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [TIMING_W-1:0] val);
    case (cfg_reg_t'(idx))
      REG_TIMEOUT_SECONDS: begin
        timeout_s   = val;
        countdown_q = COUNT_W'(timeout_s) * COUNT_W'(ticks_per_s);
      end
      REG_CYCLES_PER_SECOND: begin
        ticks_per_s = val;
        countdown_q = COUNT_W'(timeout_s) * COUNT_W'(ticks_per_s);
      end
      default: begin
        // spare indexes are ignored
      end
    endcase
  endfunction

  // apply one command beat and return the beat the block must answer with
  function automatic dim_result_t advance_dimmer(input mode_t m,
                                                 input logic signed [PCT_W-1:0] pct);
    dim_result_t r;
    int sq;
    r.changed = 1'b0;
    case (m)
      MODE_SET: take_level(pct);
      MODE_RAMP: begin
        if (cur_lvl < tgt_lvl) begin
          cur_lvl   = cur_lvl + 1'b1;
          r.changed = 1'b1;
        end else if (cur_lvl > tgt_lvl) begin
          cur_lvl   = cur_lvl - 1'b1;
          r.changed = 1'b1;
        end
      end
      MODE_TICK: begin
        // timeout disabled when timeout_seconds is zero
        if (timeout_s != '0) begin
          if (countdown_q != '0) begin
            countdown_q = countdown_q - 1'b1;
          end else begin
            // expiry applies the carried level, no decrement on this beat
            take_level(pct);
            n_expiries++;
          end
        end
      end
      default: begin
        // unused mode only reports state
      end
    endcase
    sq     = int'(cur_lvl) * int'(cur_lvl);
    r.duty = LEVEL_W'(sq / 255);
    r.cur  = cur_lvl;
    r.tgt  = tgt_lvl;
    if (r.changed) n_moves++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // port watcher: register writes, result checks, predictions
  // all sampled at the rising edge, inputs were driven at the falling edge
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : watch_ports
    dim_result_t got;
    dim_result_t want;
    if (rst_n) begin
      if (cfg_we) begin
        write_timing(cfg_index, cfg_wdata);
        n_reg_writes++;
      end
      // pop before push: the result leaving now belongs to an earlier beat
      if (out_tvalid && out_tready) begin
        got.duty    = out_tdata[OUT_DUTY_LSB +: LEVEL_W];
        got.changed = out_tdata[OUT_CHANGED_BIT];
        got.cur     = out_tdata[OUT_CUR_LSB +: LEVEL_W];
        got.tgt     = out_tdata[OUT_TGT_LSB +: LEVEL_W];
        n_results++;
        if (pending.size() == 0) begin
          $error("result beat with nothing outstanding: tdata %h", out_tdata);
          n_errors++;
        end else begin
          want = pending.pop_front();
          check_field("pwm_duty", want.duty, got.duty);
          check_field("duty_changed", want.changed, got.changed);
          check_field("current_level", want.cur, got.cur);
          check_field("target_level", want.tgt, got.tgt);
        end
      end
      if (in_tvalid && in_tready) begin
        pending.push_back(advance_dimmer(mode_t'(in_tdata[MODE_W-1:0]),
                                         in_tdata[MODE_W +: PCT_W]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random ready, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  initial begin : drive_ready
    logic stall_seen;
    int   stall_left;
    stall_seen = 1'b0;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_tog != stall_seen) begin
        stall_seen = stall_tog;
        stall_left = stall_len;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared sender and helpers, all entered and left just after a falling edge
  // ---------------------------------------------------------------------------

  // offer one command beat and hold it until taken; tvalid stays high on exit
  task automatic send_cmd(input mode_t m, input logic [PCT_W-1:0] pct);
    logic [IN_DATA_W-1:0] beat;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    beat                  = '0;
    beat[MODE_W-1:0]      = m;
    beat[MODE_W +: PCT_W] = pct;
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // stop offering and wait until every owed result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending.size() != 0) @(negedge clk);
  endtask

  // one register write; only called with the block drained
  task automatic write_reg(input cfg_reg_t idx, input logic [TIMING_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_timing(input logic [TIMING_W-1:0] secs, input logic [TIMING_W-1:0] cps);
    wait_drained();
    write_reg(REG_TIMEOUT_SECONDS, secs);
    write_reg(REG_CYCLES_PER_SECOND, cps);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // clamping below zero and above 100, truncation inside the range
  task automatic test_level_mapping();
    send_cmd(MODE_SET, 16'sh8000);
    send_cmd(MODE_SET, -16'sd1);
    send_cmd(MODE_SET, 16'sd0);
    send_cmd(MODE_SET, 16'sd1);
    send_cmd(MODE_SET, 16'sd99);
    send_cmd(MODE_SET, 16'sd100);
    send_cmd(MODE_SET, 16'sd101);
    send_cmd(MODE_SET, 16'sh7fff);
  endtask

  // up to target, a step at target, back down, and the unused mode
  task automatic test_ramp();
    send_cmd(MODE_SET, 16'sd1);
    send_cmd(MODE_RAMP, 16'sd0);
    send_cmd(MODE_RAMP, 16'sd0);
    send_cmd(MODE_RAMP, 16'sd0);
    send_cmd(MODE_SET, 16'sd0);
    send_cmd(MODE_RAMP, 16'sd0);
    send_cmd(MODE_NONE, 16'sh7fff);
  endtask

  // disabled timeout, countdown to expiry, zero ticks per second, spare
  // register indexes and the widest reload
  task automatic test_timeout();
    set_timing(16'd0, 16'd0);
    send_cmd(MODE_TICK, 16'sd70);
    set_timing(16'd1, 16'd2);
    send_cmd(MODE_TICK, 16'sd70);
    send_cmd(MODE_TICK, 16'sd70);
    send_cmd(MODE_TICK, 16'sd70);
    wait_drained();
    write_reg(REG_CYCLES_PER_SECOND, 16'd0);
    send_cmd(MODE_TICK, -16'sd5);
    send_cmd(MODE_TICK, 16'sd300);
    wait_drained();
    write_reg(REG_SPARE_2, 16'hffff);
    write_reg(REG_SPARE_3, 16'hffff);
    send_cmd(MODE_TICK, 16'sd40);
    set_timing(16'hffff, 16'hffff);
    send_cmd(MODE_TICK, 16'sd40);
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    int saved_src;
    saved_src    = src_idle_pct;
    src_idle_pct = 0;
    stall_len    = 60;
    stall_tog    = ~stall_tog;
    for (int i = 0; i < 12; i++) begin
      send_cmd(i[0] ? MODE_RAMP : MODE_SET, 16'($urandom_range(100)));
    end
    wait_drained();
    src_idle_pct = saved_src;
  endtask

  // mostly sets, ramps and ticks with in-range levels, some noise on top
  task automatic test_random(input int n_items);
    int    pick;
    mode_t m;
    logic [PCT_W-1:0] pct;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 20)      m = MODE_SET;
      else if (pick < 60) m = MODE_RAMP;
      else if (pick < 95) m = MODE_TICK;
      else                m = MODE_NONE;
      pick = $urandom_range(99);
      if (pick < 60)      pct = 16'($urandom_range(100));
      else if (pick < 75) pct = 16'($urandom_range(16'hffff));
      else if (pick < 85) pct = 16'($urandom_range(200, 101));
      else if (pick < 92) pct = -16'($urandom_range(1, 50));
      else                pct = (pick[0]) ? 16'd100 : 16'd0;
      send_cmd(m, pct);
      // now and then the sender waits for every result to come home
      if ((i % 150) == 149) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    timeout_s     = '0;
    ticks_per_s   = '0;
    tgt_lvl       = '0;
    cur_lvl       = '0;
    countdown_q   = '0;
    n_errors      = 0;
    n_results     = 0;
    n_moves       = 0;
    n_expiries    = 0;
    n_reg_writes  = 0;
    stall_tog     = 1'b0;
    stall_len     = 0;
    src_idle_pct  = 18;
    sink_idle_pct = 67;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_level_mapping();
    test_ramp();
    test_timeout();
    test_backpressure();

    // phase 1: sender idles a little, receiver a lot; short timeout
    set_timing(16'd1, 16'd3);
    test_random(340);

    // phase 2: roles swapped; zero ticks per second, every tick expires
    src_idle_pct  = 67;
    sink_idle_pct = 18;
    set_timing(16'd2, 16'd0);
    test_random(330);

    // phase 3: no idling at all; random small reload
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_timing(16'($urandom_range(1, 6)), 16'($urandom_range(0, 5)));
    test_random(330);

    wait_drained();
    repeat (4) @(posedge clk);

    $display("run covered %0d result beats: %0d ramp moves, %0d timeout expiries,",
             n_results, n_moves, n_expiries);
    $display("  %0d register writes, back-pressure stall and three idle mixes", n_reg_writes);
    if (n_errors == 0 && pending.size() == 0) begin
      $display("tb_soft_ramp_dimmer_with_timeout_top: clean");
    end else begin
      $display("tb_soft_ramp_dimmer_with_timeout_top: errors");
    end
    $finish;
  end

endmodule
